FILE: rtl/core/fba_pkg.sv
`default_nettype none

package fba_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned ROW_BITS_MAX = 64;
  localparam int unsigned S_DATA_W     = 64;
  localparam int unsigned M_DATA_W     = 40;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CFG_IDX_W    = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_TOO_LARGE     = 3'd1,
    ST_NO_MEMORY     = 3'd2,
    ST_BAD_ADDRESS   = 3'd3,
    ST_NOT_ALLOCATED = 3'd4,
    ST_NOT_STARTED   = 3'd5
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_BASE  = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: rtl/core/fixed_block_allocator.sv
// Channel   Dir  tdata (low bit up)                        tuser
// s_axis    in   request_bytes[31:0], address[63:32]       op (0 alloc, 1 free)
// m_axis    out  block_address[31:0], status[34:32], pad    -
// cfg       in   cfg_idx_i 0 block_base, 1 block_count; cfg_data_i low bits
//
// A word is taken in one cycle and evaluated in the next; a free, a refused
// allocate or an allocate served from the first flag row is done in that step.
// An allocate scans rows of up to 64 used flags held in one RAM, one row per
// cycle, and stops at the first row with a free block.
// Reset clears the flags at once through a valid bit per row; no clearing pass.
// A finished result parks while the output register is full, and no new word
// is taken until it moves.
`default_nettype none

module fixed_block_allocator
  import fba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS  = 64,
  parameter int unsigned BLOCK_BYTES = 1024   // power of two
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_DATA_W-1:0]   s_axis_tdata,   // request_bytes, address
  input  wire logic                  s_axis_tuser,   // op
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [M_DATA_W-1:0]   m_axis_tdata,   // block_address, status
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ADDR_W-1:0]     cfg_data_i
);

  localparam int unsigned LOG2_BB = $clog2(BLOCK_BYTES);
  localparam int unsigned ROW_W   = (MAX_BLOCKS >= ROW_BITS_MAX) ? ROW_BITS_MAX
                                                                 : (1 << $clog2(MAX_BLOCKS));
  localparam int unsigned LOG2_RW = $clog2(ROW_W);
  localparam int unsigned ROWS    = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int unsigned ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned COL_W   = (ROW_W > 1) ? LOG2_RW : 1;
  localparam int unsigned CNT_W   = ($clog2(MAX_BLOCKS + 1) > COUNT_W) ? $clog2(MAX_BLOCKS + 1)
                                                                       : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_WAIT
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                started_q, started_d;
  op_e                 op_q, op_d;
  logic                early_q, early_d;
  status_e             early_st_q, early_st_d;
  logic [ROW_AW-1:0]   row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROWS-1:0]     valid_q, valid_d;
  logic                m_valid_q, m_valid_d;
  logic [ADDR_W-1:0]   m_addr_q, m_addr_d;
  status_e             m_status_q, m_status_d;
  logic [ADDR_W-1:0]   pend_addr_q, pend_addr_d;
  status_e             pend_status_q, pend_status_d;

  logic [CNT_W-1:0]    eff_n;
  logic                accept;
  op_e                 in_op;
  logic [ADDR_W-1:0]   in_req;
  logic [ADDR_W-1:0]   in_addr;
  logic [ADDR_W-1:0]   offset;
  logic [ADDR_W-1:0]   idx32;
  logic [ADDR_W-1:0]   row32;
  logic [ADDR_W-1:0]   col32;

  logic                ram_we;
  logic [ROW_AW-1:0]   ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [ROW_AW-1:0]   ram_raddr;
  logic [ROW_W-1:0]    ram_rdata;

  logic [ROW_W-1:0]    row_bits;
  logic [ROW_W-1:0]    beyond;
  logic [ROW_W-1:0]    masked;
  logic                found;
  logic [COL_W-1:0]    free_col;
  logic [ROW_W-1:0]    alloc_sel;
  logic [ROW_W-1:0]    free_sel;
  logic [ADDR_W-1:0]   glob_idx;
  logic [ADDR_W-1:0]   alloc_addr;
  logic                more_rows;

  logic                done;
  logic [ADDR_W-1:0]   res_addr;
  status_e             res_status;

  fba_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign eff_n = (CNT_W'(count_q) > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(count_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_op         = op_e'(s_axis_tuser);
  assign in_req        = s_axis_tdata[ADDR_W-1:0];
  assign in_addr       = s_axis_tdata[2*ADDR_W-1:ADDR_W];
  assign offset        = in_addr - base_q;
  assign idx32         = offset >> LOG2_BB;
  assign row32         = idx32 >> LOG2_RW;
  assign col32         = idx32 & ADDR_W'(ROW_W - 1);

  // Flags of a row never written read as clear.
  assign row_bits = valid_q[row_q] ? ram_rdata : '0;

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      beyond[b]    = (((ADDR_W'(row_q) << LOG2_RW) + ADDR_W'(b)) >= ADDR_W'(eff_n));
      alloc_sel[b] = (COL_W'(b) == free_col);
      free_sel[b]  = (COL_W'(b) == col_q);
    end
  end

  assign masked = row_bits | beyond;

  // Lowest clear flag in the row.
  always_comb begin
    found    = 1'b0;
    free_col = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!masked[b]) begin
        found    = 1'b1;
        free_col = COL_W'(b);
      end
    end
  end

  assign glob_idx   = (ADDR_W'(row_q) << LOG2_RW) | ADDR_W'(free_col);
  assign alloc_addr = base_q + (glob_idx << LOG2_BB);
  assign more_rows  = ((ADDR_W'(row_q) + ADDR_W'(1)) << LOG2_RW) < ADDR_W'(eff_n);

  always_comb begin
    state_d       = state_q;
    base_d        = base_q;
    count_d       = count_q;
    started_d     = started_q;
    op_d          = op_q;
    early_d       = early_q;
    early_st_d    = early_st_q;
    row_d         = row_q;
    col_d         = col_q;
    valid_d       = valid_q;
    pend_addr_d   = pend_addr_q;
    pend_status_d = pend_status_q;
    m_addr_d      = m_addr_q;
    m_status_d    = m_status_q;
    m_valid_d     = m_valid_q && !m_axis_tready;

    ram_we     = 1'b0;
    ram_waddr  = row_q;
    ram_wdata  = row_bits;
    ram_re     = 1'b0;
    ram_raddr  = row_q;
    done       = 1'b0;
    res_addr   = '0;
    res_status = ST_OK;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BLOCK_BASE:  base_d  = cfg_data_i;
        REG_BLOCK_COUNT: count_d = cfg_data_i[COUNT_W-1:0];
        default:         ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d       = in_op;
          early_d    = 1'b0;
          early_st_d = ST_OK;
          ram_re     = 1'b1;
          if (in_op == OP_ALLOC) begin
            started_d = 1'b1;
            row_d     = '0;
            col_d     = '0;
            ram_raddr = '0;
            if (in_req > ADDR_W'(BLOCK_BYTES)) begin
              early_d    = 1'b1;
              early_st_d = ST_TOO_LARGE;
            end
          end else begin
            row_d     = row32[ROW_AW-1:0];
            col_d     = col32[COL_W-1:0];
            ram_raddr = row32[ROW_AW-1:0];
            if (!started_q) begin
              early_d    = 1'b1;
              early_st_d = ST_NOT_STARTED;
            end else if (idx32 >= ADDR_W'(eff_n)) begin
              early_d    = 1'b1;
              early_st_d = ST_BAD_ADDRESS;
            end
          end
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        if (early_q) begin
          done       = 1'b1;
          res_status = early_st_q;
        end else if (op_q == OP_ALLOC) begin
          if (found) begin
            ram_we         = 1'b1;
            ram_wdata      = row_bits | alloc_sel;
            valid_d[row_q] = 1'b1;
            done           = 1'b1;
            res_addr       = alloc_addr;
            res_status     = ST_OK;
          end else if (more_rows) begin
            // advance to the next flag row
            row_d     = row_q + ROW_AW'(1);
            ram_re    = 1'b1;
            ram_raddr = row_q + ROW_AW'(1);
          end else begin
            done       = 1'b1;
            res_status = ST_NO_MEMORY;
          end
        end else begin
          done = 1'b1;
          if (|(row_bits & free_sel)) begin
            ram_we         = 1'b1;
            ram_wdata      = row_bits & ~free_sel;
            valid_d[row_q] = 1'b1;
            res_status     = ST_OK;
          end else begin
            res_status = ST_NOT_ALLOCATED;
          end
        end

        if (done) begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_d  = 1'b1;
            m_addr_d   = res_addr;
            m_status_d = res_status;
            state_d    = S_IDLE;
          end else begin
            // hold the result until the output register drains
            pend_addr_d   = res_addr;
            pend_status_d = res_status;
            state_d       = S_WAIT;
          end
        end
      end

      S_WAIT: begin
        if (m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_addr_d   = pend_addr_q;
          m_status_d = pend_status_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      base_q        <= '0;
      count_q       <= COUNT_W'(MAX_BLOCKS);
      started_q     <= 1'b0;
      op_q          <= OP_ALLOC;
      early_q       <= 1'b0;
      early_st_q    <= ST_OK;
      row_q         <= '0;
      col_q         <= '0;
      valid_q       <= '0;
      m_valid_q     <= 1'b0;
      m_addr_q      <= '0;
      m_status_q    <= ST_OK;
      pend_addr_q   <= '0;
      pend_status_q <= ST_OK;
    end else begin
      state_q       <= state_d;
      base_q        <= base_d;
      count_q       <= count_d;
      started_q     <= started_d;
      op_q          <= op_d;
      early_q       <= early_d;
      early_st_q    <= early_st_d;
      row_q         <= row_d;
      col_q         <= col_d;
      valid_q       <= valid_d;
      m_valid_q     <= m_valid_d;
      m_addr_q      <= m_addr_d;
      m_status_q    <= m_status_d;
      pend_addr_q   <= pend_addr_d;
      pend_status_q <= pend_status_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(M_DATA_W - ADDR_W - STATUS_W)'(0), m_status_q, m_addr_q};

endmodule

`default_nettype wire

FILE: rtl/core/fba_ram.sv
`default_nettype none

module fba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fba_checker.sv
`default_nettype none

module fba_checker
  import fba_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [M_DATA_W-1:0]   m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // any failure hands back address zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[ADDR_W+STATUS_W-1:ADDR_W] != ST_OK)
      |-> (m_axis_tdata[ADDR_W-1:0] == '0))
    else $error("failed request returned a nonzero address");

  // one request in flight: no word taken in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is being evaluated");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ADDR_W+STATUS_W-1:ADDR_W] != 3'd6) &&
                      (m_axis_tdata[ADDR_W+STATUS_W-1:ADDR_W] != 3'd7))
    else $error("undefined status code");

endmodule

bind fixed_block_allocator fba_checker u_fba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
